// File: design/aesp_pkg.sv
// Package with state codes, event codes and control structs of the escape sequence parser.
package aesp_pkg;

	localparam logic [3:0] ST_GROUND    = 4'd0;
	localparam logic [3:0] ST_ESC       = 4'd1;
	localparam logic [3:0] ST_ESC_INT   = 4'd2;
	localparam logic [3:0] ST_CSI_ENTRY = 4'd3;
	localparam logic [3:0] ST_CSI_PARAM = 4'd4;
	localparam logic [3:0] ST_CSI_INT   = 4'd5;
	localparam logic [3:0] ST_CSI_IGN   = 4'd6;
	localparam logic [3:0] ST_DCS_ENTRY = 4'd7;
	localparam logic [3:0] ST_DCS_PARAM = 4'd8;
	localparam logic [3:0] ST_DCS_INT   = 4'd9;
	localparam logic [3:0] ST_DCS_PASS  = 4'd10;
	localparam logic [3:0] ST_DCS_IGN   = 4'd11;
	localparam logic [3:0] ST_OSC_ENTRY = 4'd12;
	localparam logic [3:0] ST_OSC_STR   = 4'd13;
	localparam logic [3:0] ST_SOS       = 4'd14;

	localparam logic [2:0] EV_PRINT    = 3'd0;
	localparam logic [2:0] EV_EXEC     = 3'd1;
	localparam logic [2:0] EV_ESC      = 3'd2;
	localparam logic [2:0] EV_ESC2     = 3'd3;
	localparam logic [2:0] EV_CSI      = 3'd4;
	localparam logic [2:0] EV_OSC_BYTE = 3'd5;
	localparam logic [2:0] EV_OSC_END  = 3'd6;

	localparam logic [7:0] CH_CAN   = 8'h18;
	localparam logic [7:0] CH_SUB   = 8'h1A;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_BEL   = 8'h07;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       clear_seq;   // start of a new sequence
		logic       collect;     // store an intermediate byte
		logic       param_char;  // feed a parameter character
		logic       save_esc;    // keep the escape intermediate
		logic       load_out;    // load the single-result output
		logic       osc_end_out; // load an OSC end result
		logic [2:0] kind;        // event of the single result
		logic       start_csi;   // begin a CSI parameter walk
		logic       last;        // single result ends the transfer
	} aesp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic busy;  // output register full or CSI walk in progress
	} aesp_sts_t;

endpackage

// File: design/aesp_ram.sv
// Generic single-port write, single-port read RAM with registered read data.
module aesp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// File: design/aesp_ctrl.sv
// Parser state machine of the escape sequence parser.
module aesp_ctrl
	import aesp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] byte_in,
	input  aesp_sts_t  sts,
	output logic       ready,
	output aesp_cmd_t  cmd
);
	logic [3:0] state_q;
	logic [3:0] nxt;
	logic       go_en;
	logic       osc_leave;

	assign ready = !sts.busy;

	always_comb begin
		logic [7:0] c;
		logic       single;
		c = byte_in;
		cmd = '0;
		nxt = state_q;
		go_en = 1'b0;
		single = 1'b0;
		if (c == CH_CAN || c == CH_SUB) begin
			go_en = 1'b1; nxt = ST_GROUND; single = 1'b1; cmd.kind = EV_EXEC;
		end else if (c == CH_ESC) begin
			go_en = 1'b1; nxt = ST_ESC;
		end else if (c >= 8'h80 && c <= 8'h9F) begin
			go_en = 1'b1;
			case (c)
				8'h90: nxt = ST_DCS_ENTRY;
				8'h98, 8'h9E, 8'h9F: nxt = ST_SOS;
				8'h9B: nxt = ST_CSI_ENTRY;
				8'h9C: nxt = ST_GROUND;
				8'h9D: nxt = ST_OSC_ENTRY;
				default: begin
					nxt = ST_GROUND; single = 1'b1; cmd.kind = EV_EXEC;
				end
			endcase
		end else begin
			case (state_q)
				ST_ESC: begin
					if (c <= 8'h1F) begin
						single = 1'b1; cmd.kind = EV_EXEC;
					end else if (c <= 8'h2F) begin
						cmd.save_esc = 1'b1; go_en = 1'b1; nxt = ST_ESC_INT;
					end else if (c == 8'h50) begin
						go_en = 1'b1; nxt = ST_DCS_ENTRY;
					end else if (c == 8'h58 || c == 8'h5E || c == 8'h5F) begin
						go_en = 1'b1; nxt = ST_SOS;
					end else if (c == 8'h5B) begin
						go_en = 1'b1; nxt = ST_CSI_ENTRY;
					end else if (c == 8'h5D) begin
						go_en = 1'b1; nxt = ST_OSC_ENTRY;
					end else if (c != CH_DEL) begin
						single = 1'b1; cmd.kind = EV_ESC; go_en = 1'b1; nxt = ST_GROUND;
					end
				end
				ST_ESC_INT: begin
					if (c <= 8'h1F) begin
						single = 1'b1; cmd.kind = EV_EXEC;
					end else if (c <= 8'h2F) begin
						cmd.collect = 1'b1;
					end else if (c != CH_DEL) begin
						single = 1'b1; cmd.kind = EV_ESC2; go_en = 1'b1; nxt = ST_GROUND;
					end
				end
				ST_CSI_ENTRY, ST_CSI_PARAM, ST_CSI_INT: begin
					if (c <= 8'h1F) begin
						single = 1'b1; cmd.kind = EV_EXEC;
					end else if (c <= 8'h2F) begin
						cmd.collect = 1'b1; go_en = 1'b1; nxt = ST_CSI_INT;
					end else if (c <= 8'h3F) begin
						go_en = 1'b1;
						if (state_q == ST_CSI_INT || c == CH_COLON) nxt = ST_CSI_IGN;
						else if (c <= CH_SEMI) begin
							cmd.param_char = 1'b1; nxt = ST_CSI_PARAM;
						end else if (state_q == ST_CSI_ENTRY) begin
							cmd.collect = 1'b1; nxt = ST_CSI_PARAM;
						end else nxt = ST_CSI_IGN;
					end else if (c != CH_DEL) begin
						cmd.start_csi = 1'b1; go_en = 1'b1; nxt = ST_GROUND;
					end
				end
				ST_CSI_IGN: begin
					if (c <= 8'h1F) begin
						single = 1'b1; cmd.kind = EV_EXEC;
					end else if (c >= 8'h40 && c != CH_DEL) begin
						go_en = 1'b1; nxt = ST_GROUND;
					end
				end
				ST_DCS_ENTRY, ST_DCS_PARAM, ST_DCS_INT: begin
					if (c <= 8'h1F || c == CH_DEL) begin
					end else if (c <= 8'h2F) begin
						cmd.collect = 1'b1; go_en = 1'b1; nxt = ST_DCS_INT;
					end else if (c <= 8'h3F) begin
						go_en = 1'b1;
						if (state_q == ST_DCS_INT || c == CH_COLON) nxt = ST_DCS_IGN;
						else if (c <= CH_SEMI) begin
							cmd.param_char = 1'b1; nxt = ST_DCS_PARAM;
						end else if (state_q == ST_DCS_ENTRY) begin
							cmd.collect = 1'b1; nxt = ST_DCS_PARAM;
						end else nxt = ST_DCS_IGN;
					end else begin
						go_en = 1'b1; nxt = ST_DCS_PASS;
					end
				end
				ST_OSC_ENTRY: begin
					if (c >= 8'h30 && c <= 8'h39) cmd.param_char = 1'b1;
					else if (c == CH_BEL) begin
						go_en = 1'b1; nxt = ST_GROUND;
					end else if (c == CH_SEMI) begin
						go_en = 1'b1; nxt = ST_OSC_STR;
					end else begin
						single = 1'b1; cmd.kind = EV_OSC_BYTE; go_en = 1'b1; nxt = ST_OSC_STR;
					end
				end
				ST_OSC_STR: begin
					if (c == CH_BEL) begin
						go_en = 1'b1; nxt = ST_GROUND;
					end else if (c > 8'h1F) begin
						single = 1'b1; cmd.kind = EV_OSC_BYTE;
					end
				end
				ST_DCS_PASS, ST_DCS_IGN, ST_SOS: begin
				end
				default: begin
					nxt = ST_GROUND;
					single = 1'b1;
					cmd.kind = (c <= 8'h1F) ? EV_EXEC : EV_PRINT;
				end
			endcase
		end
		// Leaving an OSC state (other than entry to string) closes the string.
		osc_leave = go_en && (state_q == ST_OSC_ENTRY || state_q == ST_OSC_STR)
			&& !(state_q == ST_OSC_ENTRY && nxt == ST_OSC_STR);
		cmd.osc_end_out = osc_leave;
		cmd.load_out = single;
		cmd.last = 1'b1;
		cmd.clear_seq = go_en && (nxt == ST_ESC || nxt == ST_CSI_ENTRY
			|| nxt == ST_DCS_ENTRY || nxt == ST_OSC_ENTRY);
		if (!take)
			cmd = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_GROUND;
		end else if (take) begin
			state_q <= nxt;
		end
	end
endmodule

// File: design/aesp_dp.sv
// Datapath of the escape sequence parser: sequence storage, CSI walk and output registers.
module aesp_dp
	import aesp_pkg::*;
#(
	parameter int MAX_PARAMS = 16,
	parameter int KEPT_INTERMEDIATES = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  byte_in,
	input  aesp_cmd_t   cmd,
	input  logic        out_take,
	output aesp_sts_t   sts,
	output logic        out_valid,
	output logic [2:0]  event_kind,
	output logic [7:0]  code,
	output logic [1:0]  inter_count,
	output logic [7:0]  inter_first,
	output logic [7:0]  inter_second,
	output logic [3:0]  param_index,
	output logic [15:0] param_value,
	output logic [4:0]  param_count,
	output logic        param_overflow,
	output logic        last
);
	localparam int AW = $clog2(MAX_PARAMS);
	localparam int TW = $clog2(MAX_PARAMS + 1);
	localparam int KW = (KEPT_INTERMEDIATES > 1) ? $clog2(KEPT_INTERMEDIATES) : 1;

	logic [TW-1:0] ptot_q;
	logic          pdrop_q;
	logic          lead0_q;    // parameter zero was closed empty by a leading separator
	logic [15:0]   cur_q;      // value of the newest parameter
	logic [15:0]   first_q;    // value of parameter zero (OSC number)
	logic [7:0]    ib_q [KEPT_INTERMEDIATES];
	logic [1:0]    itot_q;
	logic [7:0]    escb_q;

	// CSI walk.
	logic          walk_q;     // reading parameters from RAM
	logic          rd_q;       // RAM data valid for walk index rd_idx_q
	logic [TW-1:0] widx_q;     // next index to read
	logic [AW-1:0] rd_idx_q;
	logic [7:0]    fin_q;
	logic [TW-1:0] wtot_q;

	logic          ovalid_q;

	// RAM write port: the newest parameter is written back whenever it changes.
	logic          we;
	logic [AW-1:0] waddr;
	logic [15:0]   wdata;
	logic [AW-1:0] raddr;
	logic [15:0]   rdata;

	aesp_ram #(.WIDTH(16), .DEPTH(MAX_PARAMS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	function automatic logic [7:0] inter_at(input logic [1:0] tot, input int k,
			input logic [7:0] b);
		return (tot > 2'(k) && k < KEPT_INTERMEDIATES) ? b : 8'h00;
	endfunction

	logic [7:0] ib0, ib1;
	assign ib0 = inter_at(itot_q, 0, ib_q[0]);
	assign ib1 = inter_at(itot_q, 1, ib_q[KW'(1 % KEPT_INTERMEDIATES)]);

	// Parameter character handling.
	logic          need_new0;  // implicit first parameter
	logic [TW-1:0] tot_a;
	logic          drop_a;
	logic          is_semi;
	logic          is_dig;
	logic [15:0]   cur_a;
	logic [15:0]   cur_n;
	logic [TW-1:0] tot_n;
	logic          drop_n;
	logic [19:0]   mul;

	always_comb begin
		is_semi = byte_in == CH_SEMI;
		is_dig = byte_in >= 8'h30 && byte_in <= 8'h39;
		need_new0 = ptot_q == '0;
		tot_a = need_new0 ? TW'(1) : ptot_q;
		drop_a = pdrop_q;
		cur_a = need_new0 ? 16'h0 : cur_q;
		tot_n = tot_a;
		drop_n = drop_a;
		cur_n = cur_a;
		mul = {cur_a, 3'b000} + {3'b000, cur_a, 1'b0} + {12'h0, byte_in - 8'h30};
		if (is_semi) begin
			if (tot_a < TW'(MAX_PARAMS)) begin
				tot_n = tot_a + TW'(1);
				cur_n = 16'h0;
			end else drop_n = 1'b1;
		end else if (is_dig && !drop_a) begin
			cur_n = mul[15:0];
		end
		we = cmd.param_char && !(is_semi && tot_a >= TW'(MAX_PARAMS))
			&& !(is_dig && drop_a && !need_new0);
		waddr = AW'(tot_n - TW'(1));
		wdata = cur_n;
		// A waiting read keeps its address so the data holds while the output stalls.
		raddr = rd_q ? rd_idx_q : (walk_q ? widx_q[AW-1:0] : '0);
	end

	assign sts.busy = ovalid_q || walk_q || rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptot_q <= '0;
			pdrop_q <= 1'b0;
			lead0_q <= 1'b0;
			itot_q <= '0;
			walk_q <= 1'b0;
			rd_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_take)
				ovalid_q <= 1'b0;
			if (cmd.clear_seq) begin
				ptot_q <= '0;
				pdrop_q <= 1'b0;
				lead0_q <= 1'b0;
				itot_q <= '0;
			end
			if (cmd.collect && itot_q != 2'd3)
				itot_q <= itot_q + 2'd1;
			if (cmd.param_char) begin
				ptot_q <= tot_n;
				pdrop_q <= drop_n;
				if (need_new0 && is_semi) lead0_q <= 1'b1;
			end
			if (cmd.load_out || cmd.osc_end_out)
				ovalid_q <= 1'b1;
			if (cmd.start_csi) begin
				if (ptot_q == '0) ovalid_q <= 1'b1;
				else begin
					walk_q <= 1'b1;
					widx_q <= '0;
				end
			end
			// Read one parameter at a time; each waits in rd_q until the output register drains.
			if (walk_q && !rd_q) begin
				rd_q <= 1'b1;
				rd_idx_q <= widx_q[AW-1:0];
				widx_q <= widx_q + TW'(1);
				if (widx_q + TW'(1) == wtot_q) walk_q <= 1'b0;
			end
			if (rd_q && (!ovalid_q || out_take)) begin
				rd_q <= 1'b0;
				ovalid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.param_char) begin
			cur_q <= cur_n;
			if (tot_n == TW'(1)) first_q <= cur_n;
		end
		if (cmd.save_esc) escb_q <= byte_in;
		if (cmd.collect && itot_q < 2'(KEPT_INTERMEDIATES))
			ib_q[KW'(itot_q)] <= byte_in;
		if (cmd.start_csi) begin
			fin_q <= byte_in;
			wtot_q <= ptot_q;
		end
		if (cmd.load_out || cmd.osc_end_out || (cmd.start_csi && ptot_q == '0)) begin
			code <= 8'h00;
			inter_count <= 2'd0;
			inter_first <= 8'h00;
			inter_second <= 8'h00;
			param_index <= 4'd0;
			param_value <= 16'h0;
			param_count <= 5'd0;
			param_overflow <= 1'b0;
			last <= 1'b1;
		end
		if (cmd.osc_end_out) begin
			event_kind <= EV_OSC_END;
			param_value <= (ptot_q != '0) ? first_q : 16'h0;
			param_count <= (ptot_q != '0) ? 5'd1 : 5'd0;
			last <= cmd.last;
		end
		if (cmd.load_out) begin
			event_kind <= cmd.kind;
			code <= byte_in;
			if (cmd.kind == EV_ESC2) begin
				inter_count <= (itot_q == 2'd3) ? 2'd3 : itot_q + 2'd1;
				inter_first <= escb_q;
				inter_second <= ib0;
			end
		end
		if (cmd.start_csi && ptot_q == '0) begin
			event_kind <= EV_CSI;
			code <= byte_in;
			inter_count <= itot_q;
			inter_first <= ib0;
			inter_second <= ib1;
			param_overflow <= pdrop_q;
		end
		if (rd_q && (!ovalid_q || out_take)) begin
			event_kind <= EV_CSI;
			code <= fin_q;
			inter_count <= itot_q;
			inter_first <= ib0;
			inter_second <= ib1;
			param_index <= 4'(rd_idx_q);
			param_value <= (lead0_q && rd_idx_q == '0) ? 16'h0 : rdata;
			param_count <= 5'(ptot_q);
			param_overflow <= pdrop_q;
			last <= (TW'(rd_idx_q) + TW'(1)) == wtot_q;
		end
	end

	assign out_valid = ovalid_q;
endmodule

// File: design/ansi_escape_sequence_parser.sv
// Top level of the DEC/ANSI terminal escape sequence parser.
// One terminal byte is taken per input transfer and produces zero or more result
// transfers. A byte that yields no result does not hold the input. For a byte that
// yields one result (print, execute, escape, OSC byte), the block takes no new byte
// while the result still waits, so a stalled output holds the input. A byte leaving
// an OSC string that also yields another event is not possible except for CAN, SUB
// and other C1 executes, which give an OSC end then the execute. A CSI final byte
// with N kept parameters reads them one at a time from the parameter RAM (one read
// port, registered), giving N results with the parser stalled meanwhile; with no
// parameters it gives one result.
// The DCS string is swallowed.
module ansi_escape_sequence_parser
	import aesp_pkg::*;
#(
	parameter int MAX_PARAMS = 16,
	parameter int KEPT_INTERMEDIATES = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic [7:0]  code,
	output logic [1:0]  inter_count,
	output logic [7:0]  inter_first,
	output logic [7:0]  inter_second,
	output logic [3:0]  param_index,
	output logic [15:0] param_value,
	output logic [4:0]  param_count,
	output logic        param_overflow,
	output logic        last
);
	aesp_cmd_t cmd;
	aesp_sts_t sts;
	logic      ready;
	logic      take;
	logic      out_take;
	logic      pend_q;   // execute waiting behind an OSC end result
	logic [7:0] pbyte_q;
	logic      two_ev;

	assign out_take = out_valid && !out_stall;
	// A byte that gives both an OSC end and an execute is held as pending.
	assign in_stall = !ready || pend_q;
	assign take = in_valid && !in_stall;

	aesp_cmd_t cmd_c;
	aesp_cmd_t cmd_d;
	logic [7:0] byte_d;

	aesp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .take(take), .byte_in(byte_in),
		.sts(sts), .ready(ready), .cmd(cmd_c)
	);

	assign two_ev = cmd_c.osc_end_out && cmd_c.load_out;

	always_comb begin
		cmd_d = cmd_c;
		byte_d = byte_in;
		// The OSC end goes first and is not the final result of the byte.
		if (two_ev) begin
			cmd_d.load_out = 1'b0;
			cmd_d.last = 1'b0;
		end
		if (pend_q && !sts.busy) begin
			cmd_d = '0;
			cmd_d.load_out = 1'b1;
			cmd_d.kind = EV_EXEC;
			cmd_d.last = 1'b1;
			byte_d = pbyte_q;
		end
	end
	assign cmd = cmd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (two_ev) begin
			pend_q <= 1'b1;
		end else if (pend_q && !sts.busy) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (two_ev) pbyte_q <= byte_in;
	end

	aesp_dp #(.MAX_PARAMS(MAX_PARAMS), .KEPT_INTERMEDIATES(KEPT_INTERMEDIATES)) u_dp (
		.clk(clk), .arst_n(arst_n), .byte_in(byte_d), .cmd(cmd), .out_take(out_take),
		.sts(sts), .out_valid(out_valid), .event_kind(event_kind), .code(code),
		.inter_count(inter_count), .inter_first(inter_first), .inter_second(inter_second),
		.param_index(param_index), .param_value(param_value), .param_count(param_count),
		.param_overflow(param_overflow), .last(last)
	);
endmodule

// File: design/aesp_checker.sv
// Port-level checker of the escape sequence parser and its bind statement.
module aesp_checker
	import aesp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] event_kind,
	input logic       last
);
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_kind <= EV_OSC_END) else $error("bad event kind");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_kind))
		else $error("stalled result changed");
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == EV_PRINT || event_kind == EV_ESC
		|| event_kind == EV_OSC_BYTE) |-> last) else $error("single result without last");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall) else $error("input taken while result waits");
endmodule

bind ansi_escape_sequence_parser aesp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .event_kind(event_kind), .last(last)
);

// File: tb/tb_ansi_escape_sequence_parser.sv
// Testbench for the terminal escape sequence parser: byte stream stimulus, predicted events checked.
module tb_ansi_escape_sequence_parser;
	import aesp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PARAM_LIMIT = 16;
	localparam int INTER_KEPT = 2;

	// One expected or observed event of the parser.
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  code;
		logic [1:0]  icount;
		logic [7:0]  i1;
		logic [7:0]  i2;
		logic [3:0]  pidx;
		logic [15:0] pval;
		logic [4:0]  pcount;
		logic        povf;
		logic        last;
	} term_event_t;

	// Scoreboard: it keeps a shadow of the parser state, turns each accepted byte
	// into the events the block must produce, and checks results in order.
	class parser_scoreboard;
		logic [3:0]  state;
		logic [15:0] pvals[PARAM_LIMIT];
		int          ptotal;
		logic        pdropped;
		logic [7:0]  ibytes[INTER_KEPT];
		int          itotal;
		logic [7:0]  esc_first;
		term_event_t pending[$];
		term_event_t step_events[$];
		int          mismatches;

		function new();
			state = ST_GROUND;
			ptotal = 0;
			pdropped = 0;
			itotal = 0;
			esc_first = 0;
			mismatches = 0;
		endfunction

		function void add_event(logic [2:0] k, logic [7:0] c, int ic, logic [7:0] a,
				logic [7:0] b, int pi, logic [15:0] pv, int pc, logic ov);
			term_event_t e;
			e.kind = k;
			e.code = c;
			e.icount = ic[1:0];
			e.i1 = a;
			e.i2 = b;
			e.pidx = pi[3:0];
			e.pval = pv;
			e.pcount = pc[4:0];
			e.povf = ov;
			e.last = 0;
			step_events = {step_events, e};
		endfunction

		// State change; leaving an OSC string reports its end exactly once.
		function void move_to(logic [3:0] nxt);
			if ((state == ST_OSC_ENTRY || state == ST_OSC_STR) &&
					!(state == ST_OSC_ENTRY && nxt == ST_OSC_STR))
				add_event(EV_OSC_END, 0, 0, 0, 0, 0, ptotal > 0 ? pvals[0] : 16'd0,
					ptotal > 0 ? 1 : 0, 0);
			state = nxt;
			if (nxt == ST_ESC || nxt == ST_CSI_ENTRY || nxt == ST_DCS_ENTRY ||
					nxt == ST_OSC_ENTRY) begin
				ptotal = 0;
				pdropped = 0;
				itotal = 0;
			end
		endfunction

		function void collect(logic [7:0] c);
			if (itotal < INTER_KEPT)
				ibytes[itotal] = c;
			if (itotal < 3)
				itotal++;
		endfunction

		function void open_param();
			if (ptotal < PARAM_LIMIT) begin
				pvals[ptotal] = 0;
				ptotal++;
			end else begin
				pdropped = 1;
			end
		endfunction

		function void param_char(logic [7:0] c);
			if (ptotal == 0)
				open_param();
			if (c == CH_SEMI)
				open_param();
			else if (c >= "0" && c <= "9" && !pdropped && ptotal > 0)
				pvals[ptotal-1] = pvals[ptotal-1] * 16'd10 + 16'(c - "0");
		endfunction

		function logic [7:0] inter_at(int k);
			if (itotal > k && k < INTER_KEPT)
				return ibytes[k];
			return 0;
		endfunction

		function void dispatch_csi(logic [7:0] c);
			if (ptotal == 0)
				add_event(EV_CSI, c, itotal, inter_at(0), inter_at(1), 0, 0, 0, pdropped);
			else
				for (int i = 0; i < ptotal; i++)
					add_event(EV_CSI, c, itotal, inter_at(0), inter_at(1), i, pvals[i],
						ptotal, pdropped);
		endfunction

		// Note an accepted input byte.
		function void note_byte(logic [7:0] c);
			logic [3:0] s;
			s = state;
			step_events.delete();
			if (c == CH_CAN || c == CH_SUB) begin
				move_to(ST_GROUND);
				add_event(EV_EXEC, c, 0, 0, 0, 0, 0, 0, 0);
			end else if (c == CH_ESC) begin
				move_to(ST_ESC);
			end else if (c >= 8'h80 && c <= 8'h9F) begin
				if (c == 8'h90) move_to(ST_DCS_ENTRY);
				else if (c == 8'h98 || c == 8'h9E || c == 8'h9F) move_to(ST_SOS);
				else if (c == 8'h9B) move_to(ST_CSI_ENTRY);
				else if (c == 8'h9C) move_to(ST_GROUND);
				else if (c == 8'h9D) move_to(ST_OSC_ENTRY);
				else begin
					move_to(ST_GROUND);
					add_event(EV_EXEC, c, 0, 0, 0, 0, 0, 0, 0);
				end
			end else begin
				case (s)
					ST_ESC: begin
						if (c <= 8'h1F) add_event(EV_EXEC, c, 0, 0, 0, 0, 0, 0, 0);
						else if (c <= 8'h2F) begin
							esc_first = c;
							move_to(ST_ESC_INT);
						end
						else if (c == 8'h50) move_to(ST_DCS_ENTRY);
						else if (c == 8'h58 || c == 8'h5E || c == 8'h5F) move_to(ST_SOS);
						else if (c == 8'h5B) move_to(ST_CSI_ENTRY);
						else if (c == 8'h5D) move_to(ST_OSC_ENTRY);
						else if (c != CH_DEL) begin
							add_event(EV_ESC, c, 0, 0, 0, 0, 0, 0, 0);
							move_to(ST_GROUND);
						end
					end
					ST_ESC_INT: begin
						if (c <= 8'h1F) add_event(EV_EXEC, c, 0, 0, 0, 0, 0, 0, 0);
						else if (c <= 8'h2F) collect(c);
						else if (c != CH_DEL) begin
							add_event(EV_ESC2, c, itotal + 1 > 3 ? 3 : itotal + 1, esc_first,
								inter_at(0), 0, 0, 0, 0);
							move_to(ST_GROUND);
						end
					end
					ST_CSI_ENTRY, ST_CSI_PARAM, ST_CSI_INT: begin
						if (c <= 8'h1F) add_event(EV_EXEC, c, 0, 0, 0, 0, 0, 0, 0);
						else if (c <= 8'h2F) begin
							collect(c);
							move_to(ST_CSI_INT);
						end else if (c <= 8'h3F) begin
							if (s == ST_CSI_INT || c == CH_COLON) move_to(ST_CSI_IGN);
							else if (c <= CH_SEMI) begin
								param_char(c);
								move_to(ST_CSI_PARAM);
							end else if (s == ST_CSI_ENTRY) begin
								collect(c);
								move_to(ST_CSI_PARAM);
							end else move_to(ST_CSI_IGN);
						end else if (c != CH_DEL) begin
							dispatch_csi(c);
							move_to(ST_GROUND);
						end
					end
					ST_CSI_IGN: begin
						if (c <= 8'h1F) add_event(EV_EXEC, c, 0, 0, 0, 0, 0, 0, 0);
						else if (c >= 8'h40 && c != CH_DEL) move_to(ST_GROUND);
					end
					ST_DCS_ENTRY, ST_DCS_PARAM, ST_DCS_INT: begin
						if (c <= 8'h1F || c == CH_DEL) begin
						end else if (c <= 8'h2F) begin
							collect(c);
							move_to(ST_DCS_INT);
						end else if (c <= 8'h3F) begin
							if (s == ST_DCS_INT || c == CH_COLON) move_to(ST_DCS_IGN);
							else if (c <= CH_SEMI) begin
								param_char(c);
								move_to(ST_DCS_PARAM);
							end else if (s == ST_DCS_ENTRY) begin
								collect(c);
								move_to(ST_DCS_PARAM);
							end else move_to(ST_DCS_IGN);
						end else move_to(ST_DCS_PASS);
					end
					ST_DCS_PASS, ST_DCS_IGN, ST_SOS: begin
					end
					ST_OSC_ENTRY: begin
						if (c >= "0" && c <= "9") param_char(c);
						else if (c == CH_BEL) move_to(ST_GROUND);
						else if (c == CH_SEMI) move_to(ST_OSC_STR);
						else begin
							add_event(EV_OSC_BYTE, c, 0, 0, 0, 0, 0, 0, 0);
							move_to(ST_OSC_STR);
						end
					end
					ST_OSC_STR: begin
						if (c == CH_BEL) move_to(ST_GROUND);
						else if (c > 8'h1F) add_event(EV_OSC_BYTE, c, 0, 0, 0, 0, 0, 0, 0);
					end
					default: begin
						state = ST_GROUND;
						if (c <= 8'h1F) add_event(EV_EXEC, c, 0, 0, 0, 0, 0, 0, 0);
						else add_event(EV_PRINT, c, 0, 0, 0, 0, 0, 0, 0);
					end
				endcase
			end
			if (step_events.size() > 0)
				step_events[step_events.size()-1].last = 1;
			foreach (step_events[i])
				pending = {pending, step_events[i]};
		endfunction

		// Check one accepted result against the oldest expectation.
		function void check_event(term_event_t got);
			term_event_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %h, got %h", want, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  byte_in;
	logic        out_valid;
	logic        out_stall;
	term_event_t seen;
	parser_scoreboard board;
	bit          calm;          // a stretch with no idling on either side
	bit          hold_off;      // long receiver hold-off requested

	ansi_escape_sequence_parser dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .byte_in(byte_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_kind(seen.kind), .code(seen.code), .inter_count(seen.icount),
		.inter_first(seen.i1), .inter_second(seen.i2), .param_index(seen.pidx),
		.param_value(seen.pval), .param_count(seen.pcount),
		.param_overflow(seen.povf), .last(seen.last)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Sends one byte: present it at a falling edge and hold it until a rising
	// edge sees valid high with no stall. Random gaps come first.
	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		byte_in <= b;
		do @(posedge clk); while (in_stall);
		board.note_byte(b);
		@(negedge clk);
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// A CSI sequence with random content, mostly well formed.
	task automatic send_csi();
		int n;
		n = $urandom_range(0, 99) < 10 ? $urandom_range(14, 20) : $urandom_range(0, 4);
		if ($urandom_range(0, 1)) send_byte(8'h9B);
		else begin
			send_byte(CH_ESC);
			send_byte("[");
		end
		if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(8'h3C, 8'h3F)));
		for (int i = 0; i < n; i++) begin
			if (i > 0) send_byte(CH_SEMI);
			repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range("0", "9")));
		end
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
			send_byte(8'($urandom_range(8'h20, 8'h2F)));
		if ($urandom_range(0, 19) == 0) send_byte(8'($urandom_range(0, 255)));
		send_byte(8'($urandom_range(8'h40, 8'h7E)));
	endtask

	task automatic send_osc();
		if ($urandom_range(0, 1)) send_byte(8'h9D);
		else begin
			send_byte(CH_ESC);
			send_byte("]");
		end
		repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range("0", "9")));
		if ($urandom_range(0, 3) != 0) send_byte(CH_SEMI);
		repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(8'h20, 8'hFF)));
		case ($urandom_range(0, 3))
			0: send_byte(CH_BEL);
			1: send_byte(8'h9C);
			2: send_byte(CH_CAN);
			default: send_byte(8'($urandom_range(8'h80, 8'h9F)));
		endcase
	endtask

	task automatic send_escape();
		send_byte(CH_ESC);
		repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(8'h20, 8'h2F)));
		send_byte(8'($urandom_range(8'h30, 8'hFF)));
	endtask

	task automatic send_dcs();
		send_byte($urandom_range(0, 1) ? 8'h90 : CH_ESC);
		if (byte_in == CH_ESC) send_byte("P");
		repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(0, 8'h7F)));
		send_byte(8'h9C);
	endtask

	// Receiver: random stalls, plus one long hold-off counted here.
	initial begin
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (300) @(negedge clk);
				hold_off = 0;
			end
			out_stall <= !calm && $urandom_range(0, 99) < 10;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			board.check_event(seen);

	initial begin
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_in = 8'h00;
		calm = 0;
		hold_off = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, each event but the plain escape, and the corner cases.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_DEL);
		send_string("\033[;5;;65536;99999m");
		send_string("\033[?1;2 !h");
		send_string("\033(B");
		send_string("\033 !#7");
		send_string("\033]12;ab\007");
		send_byte(8'h9D);
		send_string("5x");
		send_byte(CH_SUB);
		send_string("\033[1:2m");
		send_byte(8'h85);

		// Long hold-off while bytes keep coming so the block backs up.
		hold_off = 1;
		repeat (30) send_byte(8'($urandom_range(8'h20, 8'h7E)));

		for (int n = 0; n < 38; n++) begin
			calm = n >= 12 && n < 20;
			case ($urandom_range(0, 9))
				0, 1, 2: send_csi();
				3, 4: send_osc();
				5: send_escape();
				6: send_dcs();
				7: send_byte(8'($urandom_range(0, 255)));
				default: repeat ($urandom_range(1, 4))
					send_byte(8'($urandom_range(8'h20, 8'hFF)));
			endcase
		end
		calm = 0;
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#4ms;
		$display("FAILURE");
		$finish;
	end

endmodule

// File: filelist.f
design/aesp_pkg.sv
design/aesp_ram.sv
design/aesp_ctrl.sv
design/aesp_dp.sv
design/ansi_escape_sequence_parser.sv
design/aesp_checker.sv
tb/tb_ansi_escape_sequence_parser.sv
